### src/iorm_pkg.sv
// ----------------------------------------------------------------------------
// iorm_pkg: shared types and constants of the orientation remap unit
// Holds the mode codes, the register indexes and the fixed field widths.
// ----------------------------------------------------------------------------
package iorm_pkg;

  // Fixed widths of the port fields.
  localparam int PIX_W   = 32;
  localparam int IDX_W   = 24;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;

  // Depth of the word queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef enum logic [2:0] {
    MODE_NONE       = 3'd0,
    MODE_FLIP_H     = 3'd1,
    MODE_FLIP_V     = 3'd2,
    MODE_ROT180     = 3'd3,
    MODE_TRANSPOSE  = 3'd4,
    MODE_TRANSVERSE = 3'd5,
    MODE_ROT_CW     = 3'd6,
    MODE_ROT_CCW    = 3'd7
  } mode_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_UNUSED = 2'd3
  } reg_index_t;

  localparam logic [CFG_W-1:0] DIM_RESET = 13'd64;

endpackage

### src/iorm_front.sv
// ----------------------------------------------------------------------------
// iorm_front: configuration, position tracking and term selection
// Counts row and column of each accepted pixel and picks the row term,
// column term and stride that the back end combines into the index.
// ----------------------------------------------------------------------------
module iorm_front #(
  parameter int MAX_DIM = 4096,
  parameter int PB      = 32,
  parameter int DW      = 13,
  parameter int CW      = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [iorm_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [iorm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         accept,
  input  logic [PB-1:0]                pixel,
  output logic [PB-1:0]                ent_pix,
  output logic [iorm_pkg::IDX_W-1:0]   ent_a,
  output logic [iorm_pkg::IDX_W-1:0]   ent_b,
  output logic [DW-1:0]                ent_stride,
  output logic                         ent_last
);
  import iorm_pkg::*;

  mode_t             mode;
  logic [CFG_W-1:0]  src_width;
  logic [CFG_W-1:0]  src_height;
  logic [CW-1:0]     column_count;
  logic [CW-1:0]     row_count;
  logic [DW-1:0]     w;
  logic [DW-1:0]     h;
  logic              col_end;
  logic              row_end;
  logic [IDX_W-1:0]  r24;
  logic [IDX_W-1:0]  c24;
  logic [IDX_W-1:0]  rc24;
  logic [IDX_W-1:0]  cc24;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NONE;
      src_width  <= DIM_RESET;
      src_height <= DIM_RESET;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_MODE:   mode       <= mode_t'(cfg_data[2:0]);
        REG_WIDTH:  src_width  <= cfg_data;
        REG_HEIGHT: src_height <= cfg_data;
        REG_UNUSED: ;
      endcase
    end
  end

  // Out-of-range dimensions are pinned to 1 and MAX_DIM.
  always_comb begin
    if (src_width == '0) begin
      w = DW'(1);
    end else if (32'(src_width) > 32'(MAX_DIM)) begin
      w = DW'(MAX_DIM);
    end else begin
      w = DW'(src_width);
    end
    if (src_height == '0) begin
      h = DW'(1);
    end else if (32'(src_height) > 32'(MAX_DIM)) begin
      h = DW'(MAX_DIM);
    end else begin
      h = DW'(src_height);
    end
  end

  // A counter left past its end by a dimension change still counts as at the end.
  assign col_end = DW'(column_count) >= (w - DW'(1));
  assign row_end = DW'(row_count) >= (h - DW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : row_count + CW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // Mirrored positions wrap modulo the index width when a counter overshoots.
  assign r24  = IDX_W'(row_count);
  assign c24  = IDX_W'(column_count);
  assign rc24 = IDX_W'(h) - IDX_W'(1) - r24;
  assign cc24 = IDX_W'(w) - IDX_W'(1) - c24;

  always_comb begin
    unique case (mode)
      MODE_NONE:       begin ent_a = r24;  ent_b = c24;  ent_stride = w; end
      MODE_FLIP_H:     begin ent_a = r24;  ent_b = cc24; ent_stride = w; end
      MODE_FLIP_V:     begin ent_a = rc24; ent_b = c24;  ent_stride = w; end
      MODE_ROT180:     begin ent_a = rc24; ent_b = cc24; ent_stride = w; end
      MODE_TRANSPOSE:  begin ent_a = c24;  ent_b = r24;  ent_stride = h; end
      MODE_TRANSVERSE: begin ent_a = cc24; ent_b = rc24; ent_stride = h; end
      MODE_ROT_CW:     begin ent_a = c24;  ent_b = rc24; ent_stride = h; end
      MODE_ROT_CCW:    begin ent_a = cc24; ent_b = r24;  ent_stride = h; end
    endcase
  end

  assign ent_pix  = pixel;
  assign ent_last = col_end && row_end;

`ifndef SYNTH
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && ent_last) |=> (column_count == '0 && row_count == '0))
    else $error("position counters did not wrap after the last pixel");
`endif

endmodule

### src/iorm_queue.sv
// ----------------------------------------------------------------------------
// iorm_queue: short word queue between the front and the back
// Lets the input side keep accepting while the output side is stalled.
// ----------------------------------------------------------------------------
module iorm_queue #(
  parameter int WIDTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  import iorm_pkg::*;

  logic [WIDTH-1:0]   mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign push_ready = count != Q_CNT_W'(Q_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue holds more words than its depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");
  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + Q_CNT_W'(1))
    else $error("queue fill level missed a push");
`endif

endmodule

### src/iorm_back.sv
// ----------------------------------------------------------------------------
// iorm_back: index arithmetic and result register
// Multiplies the row term by the stride, then adds the column term into the
// output register. Both stages stall independently of the queue's input side.
// ----------------------------------------------------------------------------
module iorm_back #(
  parameter int PB = 32,
  parameter int DW = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  logic [PB-1:0]               q_pix,
  input  logic [iorm_pkg::IDX_W-1:0]  q_a,
  input  logic [iorm_pkg::IDX_W-1:0]  q_b,
  input  logic [DW-1:0]               q_stride,
  input  logic                        q_last,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [iorm_pkg::PIX_W-1:0]  pixel_out,
  output logic [iorm_pkg::IDX_W-1:0]  dest_index,
  output logic                        frame_last
);
  import iorm_pkg::*;

  logic             s1_valid;
  logic [IDX_W-1:0] s1_prod;
  logic [IDX_W-1:0] s1_b;
  logic [PB-1:0]    s1_pix;
  logic             s1_last;
  logic [PB-1:0]    out_pix;
  logic [IDX_W-1:0] prod;
  logic             adv1;
  logic             adv2;

  assign adv2  = !result_valid || result_ready;
  assign adv1  = !s1_valid || adv2;
  assign q_pop = q_valid && adv1;
  assign prod  = IDX_W'(q_a * IDX_W'(q_stride));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= q_valid;
      end
      if (adv2) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prod <= prod;
      s1_b    <= q_b;
      s1_pix  <= q_pix;
      s1_last <= q_last;
    end
    if (s1_valid && adv2) begin
      dest_index <= s1_prod + s1_b;
      out_pix    <= s1_pix;
      frame_last <= s1_last;
    end
  end

  assign pixel_out = PIX_W'(out_pix);

endmodule

### src/image_orientation_remap_unit.sv
// ----------------------------------------------------------------------------
// image_orientation_remap_unit: flip, rotate and transpose address remap
// Source pixels enter in raster order on the pixel channel (pixel_valid /
// pixel_ready). Each leaves on the result channel with its destination index
// and a flag on the last pixel of the frame. Mode, width and height are set
// through the cfg channel (index 0 mode, 1 width, 2 height); the user must
// set them only while idle, as the block does not enforce it. cfg_ready is
// always high. One pixel is taken per clock while the queue has room. An
// accepted word passes through the queue, the multiply stage and the result
// register before it is shown on the result channel. A four-word queue sits
// between the position tracker and the arithmetic, so the input side keeps
// taking words while results wait; pixel_ready drops only when that queue is
// full. Reset clears the position counters and the queue, and sets mode to
// none and both dimensions to 64. A stalled receiver holds the result steady.
// ----------------------------------------------------------------------------
module image_orientation_remap_unit #(
  parameter int MAX_DIM    = 4096,
  parameter int PIXEL_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [iorm_pkg::CIDX_W-1:0] cfg_index,
  input  logic [iorm_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  logic [iorm_pkg::PIX_W-1:0]  pixel,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [iorm_pkg::PIX_W-1:0]  pixel_out,
  output logic [iorm_pkg::IDX_W-1:0]  dest_index,
  output logic                        frame_last
);
  import iorm_pkg::*;

  localparam int PB    = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = $clog2(MAX_DIM);
  localparam int ENT_W = PB + 2 * IDX_W + DW + 1;

  logic             accept;
  logic [PB-1:0]    ent_pix;
  logic [IDX_W-1:0] ent_a;
  logic [IDX_W-1:0] ent_b;
  logic [DW-1:0]    ent_stride;
  logic             ent_last;
  logic [ENT_W-1:0] push_data;
  logic [ENT_W-1:0] pop_data;
  logic             q_valid;
  logic             q_pop;

  assign cfg_ready = 1'b1;
  assign accept    = pixel_valid && pixel_ready;

  iorm_front #(
    .MAX_DIM (MAX_DIM),
    .PB      (PB),
    .DW      (DW),
    .CW      (CW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .pixel      (pixel[PB-1:0]),
    .ent_pix    (ent_pix),
    .ent_a      (ent_a),
    .ent_b      (ent_b),
    .ent_stride (ent_stride),
    .ent_last   (ent_last)
  );

  assign push_data = {ent_last, ent_stride, ent_b, ent_a, ent_pix};

  iorm_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (push_data),
    .push_ready (pixel_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (pop_data)
  );

  iorm_back #(
    .PB (PB),
    .DW (DW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_pix        (pop_data[PB-1:0]),
    .q_a          (pop_data[PB +: IDX_W]),
    .q_b          (pop_data[PB + IDX_W +: IDX_W]),
    .q_stride     (pop_data[PB + 2 * IDX_W +: DW]),
    .q_last       (pop_data[ENT_W-1]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .dest_index   (dest_index),
    .frame_last   (frame_last)
  );

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the image orientation remap unit
// Feeds raster-order pixels under many mode and dimension settings, predicts
// each pixel's destination index and end-of-frame flag, and compares every
// result word against the prediction, with random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb;
  import iorm_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  localparam int IDLE_LIMIT   = 1000;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [IDX_W-1:0] index;
    logic             last;
  } remap_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              pixel_valid = 1'b0;
  logic              pixel_ready;
  logic [PIX_W-1:0]  pixel = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [PIX_W-1:0]  pixel_out;
  logic [IDX_W-1:0]  dest_index;
  logic              frame_last;

  // Shadow of the block's registers and position counters.
  mode_t             remap_mode = MODE_NONE;
  logic [CFG_W-1:0]  width_reg = DIM_RESET;
  logic [CFG_W-1:0]  height_reg = DIM_RESET;
  logic [31:0]       col_pos = '0;
  logic [31:0]       row_pos = '0;

  logic [PIX_W-1:0]  pending_pixels[$];
  remap_word_t       landing_q[$];
  remap_word_t       want;
  logic              pix_fire = 1'b0;
  int                fail_count = 0;
  int                idle_cycles = 0;
  int                burst_left = 0;
  int                gap_left = 0;
  int                hold_left = 0;
  bit                long_hold_done = 1'b0;
  logic [15:0]       stall_pat = '1;
  logic [5:0]        pat_age = '0;

  image_orientation_remap_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .dest_index   (dest_index),
    .frame_last   (frame_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 32'd1;
    if (v > 13'd4096) return 32'd4096;
    return 32'(v);
  endfunction

  // Computes where the next raster pixel lands and advances the position.
  function automatic remap_word_t predict_landing(input logic [PIX_W-1:0] px);
    logic [31:0] w, h, r, c, rc, cc, idx;
    logic        col_end, row_end;
    remap_word_t res;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    r = row_pos;
    c = col_pos;
    rc = h - 32'd1 - r;
    cc = w - 32'd1 - c;
    col_end = c >= w - 32'd1;
    row_end = r >= h - 32'd1;
    case (remap_mode)
      MODE_NONE:       idx = r * w + c;
      MODE_FLIP_H:     idx = r * w + cc;
      MODE_FLIP_V:     idx = rc * w + c;
      MODE_ROT180:     idx = rc * w + cc;
      MODE_TRANSPOSE:  idx = c * h + r;
      MODE_TRANSVERSE: idx = cc * h + rc;
      MODE_ROT_CW:     idx = c * h + rc;
      default:         idx = cc * h + r;
    endcase
    res.pix = px;
    res.index = idx[IDX_W-1:0];
    res.last = col_end && row_end;
    if (col_end) begin
      col_pos = '0;
      row_pos = row_end ? 32'd0 : r + 32'd1;
    end else begin
      col_pos = c + 32'd1;
    end
    return res;
  endfunction

  // Acceptance, prediction and checking, all on the rising edge.
  always @(posedge clk) begin
    pix_fire <= !rst && pixel_valid && pixel_ready;
    if (!rst && cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_MODE:   remap_mode = mode_t'(cfg_data[2:0]);
        REG_WIDTH:  width_reg = cfg_data;
        REG_HEIGHT: height_reg = cfg_data;
        default:    ;
      endcase
    end
    if (!rst && pixel_valid && pixel_ready) begin
      landing_q.push_back(predict_landing(pixel));
    end
    if (!rst && result_valid && result_ready) begin
      if (landing_q.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        want = landing_q.pop_front();
        if (pixel_out !== want.pix) begin
          $error("pixel_out: expected %h, got %h", want.pix, pixel_out);
          fail_count++;
        end
        if (dest_index !== want.index) begin
          $error("dest_index: expected %0d, got %0d", want.index, dest_index);
          fail_count++;
        end
        if (frame_last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, frame_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Pixel sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || pix_fire) begin
      if (gap_left > 0 || pending_pixels.size() == 0) begin
        if (gap_left > 0) gap_left--;
        pixel_valid <= 1'b0;
      end else begin
        pixel_valid <= 1'b1;
        pixel <= pending_pixels.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
  end

  // Result receiver: a rotating stall pattern, replaced at random when its age
  // counter wraps, plus occasional long hold-offs while the sender offers words.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (!long_hold_done && pending_pixels.size() >= 30) begin
      long_hold_done = 1'b1;
      hold_left = 200;
      result_ready <= 1'b0;
    end else if ($urandom_range(0, 2047) == 0) begin
      hold_left = 40;
      result_ready <= 1'b0;
    end else begin
      result_ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      pat_age++;
      if (pat_age == '0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = '1;
          1:       stall_pat = 16'($urandom);
          2:       stall_pat = 16'($urandom) | 16'($urandom);
          default: stall_pat = (16'($urandom) & 16'($urandom)) | 16'h0001;
        endcase
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic reconfigure(input bit wr_mode, input bit wr_width, input bit wr_height,
                             input mode_t m, input logic [CFG_W-1:0] w,
                             input logic [CFG_W-1:0] h);
    logic [CFG_W-1:0] mode_word;
    mode_word = CFG_W'($urandom);
    mode_word[2:0] = m;
    if (wr_mode) write_reg(REG_MODE, mode_word);
    if (wr_width) write_reg(REG_WIDTH, w);
    if (wr_height) write_reg(REG_HEIGHT, h);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every pixel has gone out and been checked, then lets the
  // pipeline settle.
  task automatic drain();
    while (pending_pixels.size() != 0 || pixel_valid || landing_q.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 13'd4096;
      2:       return CFG_W'($urandom_range(4097, 8191));
      3:       return 13'd1;
      4, 5:    return CFG_W'($urandom_range(13, 300));
      default: return CFG_W'($urandom_range(2, 12));
    endcase
  endfunction

  initial begin
    int sent;
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: mode none, 64 by 64.
    pending_pixels.push_back('0);
    pending_pixels.push_back('1);
    drain();

    // Shrinking the frame mid-row leaves the column past its end; it must wrap.
    reconfigure(1, 1, 1, MODE_NONE, 13'd2, 13'd2);
    repeat (3) pending_pixels.push_back($urandom);
    drain();

    // Largest frame from its first pixel gives the top destination index.
    write_reg(REG_UNUSED, CFG_W'($urandom));
    reconfigure(1, 1, 1, MODE_ROT180, 13'd4096, 13'd4096);
    pending_pixels.push_back('1);
    drain();

    // Zero width behaves as one, oversize height as the maximum.
    reconfigure(1, 1, 1, MODE_TRANSVERSE, 13'd0, 13'd8191);
    repeat (2) pending_pixels.push_back($urandom);
    drain();

    for (int m = 0; m < 8; m++) begin
      reconfigure(1, 1, 1, mode_t'(m), 13'd2, 13'd1);
      pending_pixels.push_back($urandom);
      pending_pixels.push_back($urandom);
      drain();
    end

    // Random phases: the first is long enough to back the block up.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      reconfigure($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                  $urandom_range(0, 3) != 0, mode_t'($urandom_range(0, 7)),
                  pick_dim(), pick_dim());
      n = (sent == 0) ? 64 : $urandom_range(1, 60);
      repeat (n) pending_pixels.push_back($urandom);
      sent += n;
      drain();
    end

    if (landing_q.size() != 0) begin
      $error("%0d expected result words never arrived", landing_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### files.f
src/iorm_pkg.sv
src/iorm_front.sv
src/iorm_queue.sv
src/iorm_back.sv
src/image_orientation_remap_unit.sv
tb/tb.sv
